>>> rtl/cimwf_pkg.sv
// Shared types, register indexes and the case-folding helper for the word filter.
package cimwf_pkg;

  localparam int SLOT_REGS  = 4;
  localparam int WORD_W     = 64;
  localparam int LENGTHS_W  = 16;
  localparam int CFG_IDX_W  = 3;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_ZERO    = 3'd0,
    CFG_WORD_ONE     = 3'd1,
    CFG_WORD_TWO     = 3'd2,
    CFG_WORD_THREE   = 3'd3,
    CFG_WORD_LENGTHS = 3'd4
  } cfg_index_t;

  localparam byte_t UPPER_A    = 8'h41;
  localparam byte_t UPPER_Z    = 8'h5A;
  localparam byte_t CASE_DELTA = 8'h20;

  // Fold ASCII A-Z to lower case, pass every other byte through.
  function automatic byte_t fold_lower(input byte_t c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

endpackage

>>> rtl/case_insensitive_multi_word_filter.sv
// Streaming multi-word substring filter with case folding of the message text.
//
// Usage:
//   Text channel: text_valid/text_stall carry one request per message byte
//   (text_byte) with end_of_text marking the final byte.  Result channel:
//   result_valid/result_stall carry one request per message, violation set
//   when any enabled forbidden word occurred anywhere in that message.
//   Config channel: cfg_valid/cfg_ready with cfg_index 0..3 for the words
//   (character 0 in bits 7:0) and 4 for the packed 4-bit lengths.  cfg_ready
//   is always high; indexes above 4 are dropped.  Write only while idle.
// Throughput: one byte per cycle, except while a final byte waits (see Stall).
//   A byte is registered at acceptance; from that register all words compare
//   in parallel against the shift window of recent folded bytes, the message
//   state advances and, for the final byte, the result register loads once it
//   can take the flag.
// Stall: the result register parts the two sides.  Only a final byte waits,
//   and only while an earlier result is still held under result_stall;
//   non-final bytes keep flowing.
// Reset: rst clears all words and lengths (every slot disabled), the byte
//   count and match flag of the message state and both valid flags.
module case_insensitive_multi_word_filter
  import cimwf_pkg::*;
#(
  parameter int NUM_WORDS    = 4,
  parameter int MAX_WORD_LEN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 violation,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  // Only slots that have a word register take part.
  localparam int ACTIVE_WORDS = (NUM_WORDS < SLOT_REGS) ? NUM_WORDS : SLOT_REGS;
  localparam int HIST_DEPTH   = (MAX_WORD_LEN > 1) ? MAX_WORD_LEN - 1 : 1;
  localparam int SEEN_W       = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam logic [3:0]        MAX_LEN  = 4'(MAX_WORD_LEN);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_WORD_LEN - 1);

  // Configuration registers.
  logic [WORD_W-1:0]    words [SLOT_REGS];
  logic [LENGTHS_W-1:0] word_lengths;

  // Input register.
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_last;

  // Message state.
  byte_t             recent [HIST_DEPTH];
  logic [SEEN_W-1:0] bytes_seen;
  logic              hit_so_far;

  // Comparison window and match result.
  byte_t      win [MAX_WORD_LEN];
  logic       hit_any;
  logic [3:0] eff_len;
  logic [2:0] pos;
  logic       slot_ok;

  logic s1_go;
  logic out_free;
  logic text_take;

  assign cfg_ready = 1'b1;

  // Config writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOT_REGS; k++) begin
        words[k] <= '0;
      end
      word_lengths <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WORD_ZERO:    words[0] <= cfg_data;
        CFG_WORD_ONE:     words[1] <= cfg_data;
        CFG_WORD_TWO:     words[2] <= cfg_data;
        CFG_WORD_THREE:   words[3] <= cfg_data;
        CFG_WORD_LENGTHS: word_lengths <= cfg_data[LENGTHS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a final byte holds in the input register until the result
  // register can take its flag.
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_last || out_free);
  assign text_stall = s1_valid && !s1_go;
  assign text_take  = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Fold on the way in so the compare stage sees lower-case text.
  always_ff @(posedge clk) begin
    if (text_take) begin
      s1_byte <= fold_lower(text_byte);
      s1_last <= end_of_text;
    end
  end

  // Window ending at the current byte: entry 0 is the current byte.
  always_comb begin
    win[0] = s1_byte;
    for (int i = 1; i < MAX_WORD_LEN; i++) begin
      win[i] = recent[i-1];
    end
  end

  // Compare every enabled slot in parallel.  Character position of window
  // entry i is len-1-i, so the word's last character meets the current byte.
  always_comb begin
    hit_any = hit_so_far;
    eff_len = '0;
    pos     = '0;
    slot_ok = 1'b0;
    for (int k = 0; k < ACTIVE_WORDS; k++) begin
      eff_len = word_lengths[4*k +: 4];
      if (eff_len > MAX_LEN) begin
        eff_len = MAX_LEN;
      end
      // Length zero disables the slot; a word longer than the message so far
      // cannot have ended here.
      slot_ok = (eff_len != 4'd0) && ((4'(bytes_seen) + 4'd1) >= eff_len);
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
        if (4'(i) < eff_len) begin
          pos = 3'(eff_len - 4'(i) - 4'd1);
          if (words[k][{pos, 3'b000} +: 8] != win[i]) begin
            slot_ok = 1'b0;
          end
        end
      end
      hit_any = hit_any | slot_ok;
    end
  end

  // Message state: advance on a non-final byte, clear after the final one.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      hit_so_far <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        bytes_seen <= '0;
        hit_so_far <= 1'b0;
      end else begin
        if (bytes_seen < SEEN_MAX) begin
          bytes_seen <= bytes_seen + 1'b1;
        end
        hit_so_far <= hit_any;
      end
    end
  end

  // Shift window; entries past bytes_seen are never compared, so no clearing.
  always_ff @(posedge clk) begin
    if (s1_go && !s1_last) begin
      recent[0] <= s1_byte;
      for (int j = 1; j < HIST_DEPTH; j++) begin
        recent[j] <= recent[j-1];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      violation <= hit_any;
    end
  end

  // Only a final byte facing a held result may block the text channel.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> (s1_last && result_valid && result_stall))
    else $error("text stalled without a held result");

  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= SEEN_MAX)
    else $error("byte count beyond saturation");

  a_msg_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (result_valid && !hit_so_far && bytes_seen == '0))
    else $error("message state not cleared after final byte");

  a_hit_sticky: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_last && hit_any) |=> hit_so_far)
    else $error("match not recorded");

endmodule
